// ===== sv/ppm_pkg.sv =====
// Shared types, constants and the header spacing table for the PPM interval encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

    localparam int unsigned DATA_BITS_DEF = 16;
    localparam int unsigned HDR_PULSES    = 16;
    localparam int unsigned WORD_W        = 16;
    localparam int unsigned FACTOR_W      = 7;
    localparam int unsigned TICKS_W       = 12;
    localparam int unsigned SPACE_W       = 5;
    localparam int unsigned HDR_IDX_W     = 4;
    localparam int unsigned APB_ADDR_W    = 4;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [FACTOR_W-1:0] BASE_RST  = 7'd50;
    localparam logic [FACTOR_W-1:0] LONG_RST  = 7'd55;
    localparam logic [FACTOR_W-1:0] SHORT_RST = 7'd45;
    localparam logic [TICKS_W-1:0]  START_RST = 12'd300;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_LONG  = 2'd1,
        REG_SHORT = 2'd2,
        REG_START = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [FACTOR_W-1:0] base_factor;
        logic [FACTOR_W-1:0] long_factor;
        logic [FACTOR_W-1:0] short_factor;
        logic [TICKS_W-1:0]  start_delay;
    } t_cfg;

    // one pulse slot handed from the sequencer to the interval stage
    typedef struct packed {
        logic                 is_data;
        logic [HDR_IDX_W-1:0] hdr_sel;   // header slot, 0 = start delay
        logic                 cur_bit;
        logic                 prev_bit;
        logic                 last;
    } t_beat;

    // header spacing in base_factor units; slot 0 is the start delay
    function automatic logic [SPACE_W-1:0] hdr_space(input logic [HDR_IDX_W-1:0] idx);
        logic [SPACE_W-1:0] s;
        case (idx)
            4'd1:    s = 5'd23;
            4'd2:    s = 5'd16;
            4'd3:    s = 5'd20;
            4'd4:    s = 5'd25;
            4'd5:    s = 5'd29;
            4'd6:    s = 5'd27;
            4'd7:    s = 5'd24;
            4'd8:    s = 5'd22;
            4'd9:    s = 5'd28;
            4'd10:   s = 5'd17;
            4'd11:   s = 5'd21;
            4'd12:   s = 5'd30;
            4'd13:   s = 5'd18;
            4'd14:   s = 5'd26;
            4'd15:   s = 5'd19;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ppm_ifs.sv =====
// Valid/ready channel interfaces for the word input and the pulse interval output.
// Depends on ppm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ppm_in_if;
    logic                        valid;
    logic                        ready;
    logic [ppm_pkg::WORD_W-1:0]  data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface ppm_out_if;
    logic                        valid;
    logic                        ready;
    logic [ppm_pkg::TICKS_W-1:0] interval_ticks;
    logic                        is_data_pulse;
    logic                        last_pulse;

    modport source (output valid, output interval_ticks, output is_data_pulse,
                    output last_pulse, input ready);
    modport sink   (input valid, input interval_ticks, input is_data_pulse,
                    input last_pulse, output ready);
endinterface

`default_nettype wire

// ===== sv/ppm_cfg.sv =====
// APB register file: base, long and short factors and start delay.
// Depends on ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppm_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [ppm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [ppm_pkg::APB_DATA_W-1:0] i_pwdata,
    output      logic [ppm_pkg::APB_DATA_W-1:0] o_prdata,
    output      logic                           o_pready,
    output      ppm_pkg::t_cfg                  o_cfg
);
    import ppm_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx s_idx;
    logic     s_wr;

    assign o_pready = 1'b1;
    assign s_idx    = t_reg_idx'(i_paddr[3:2]);
    assign s_wr     = i_psel & i_penable & i_pwrite & o_pready;

    always_comb begin
        n_cfg = r_cfg;
        if (s_wr) begin
            unique case (s_idx)
                REG_BASE:  n_cfg.base_factor  = i_pwdata[FACTOR_W-1:0];
                REG_LONG:  n_cfg.long_factor  = i_pwdata[FACTOR_W-1:0];
                REG_SHORT: n_cfg.short_factor = i_pwdata[FACTOR_W-1:0];
                REG_START: n_cfg.start_delay  = i_pwdata[TICKS_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_factor  <= BASE_RST;
            r_cfg.long_factor  <= LONG_RST;
            r_cfg.short_factor <= SHORT_RST;
            r_cfg.start_delay  <= START_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (s_idx)
            REG_BASE:  o_prdata = APB_DATA_W'(r_cfg.base_factor);
            REG_LONG:  o_prdata = APB_DATA_W'(r_cfg.long_factor);
            REG_SHORT: o_prdata = APB_DATA_W'(r_cfg.short_factor);
            REG_START: o_prdata = APB_DATA_W'(r_cfg.start_delay);
            default:   o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/ppm_seq.sv =====
// Frame sequencer: holds the accepted word and steps through header and data slots.
// Depends on ppm_pkg and ppm_in_if.
`timescale 1ns / 1ps
`default_nettype none

module ppm_seq #(
    parameter int unsigned DATA_BITS = ppm_pkg::DATA_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ppm_in_if.sink        i_in,
    input  wire logic     i_adv_ok,   // interval stage can take a slot
    output      logic     o_beat_valid,
    output ppm_pkg::t_beat o_beat
);
    import ppm_pkg::*;

    localparam int unsigned TOTAL  = HDR_PULSES + DATA_BITS;
    localparam int unsigned BEAT_W = $clog2(TOTAL);
    localparam int unsigned LOAD_W = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;

    logic                 r_busy,  n_busy;
    logic [BEAT_W-1:0]    r_beat,  n_beat;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic                 r_prev,  n_prev;
    logic                 s_adv;
    logic                 s_last;
    logic                 s_is_data;
    logic                 s_take;

    assign s_last    = (r_beat == BEAT_W'(TOTAL - 1));
    assign s_is_data = (r_beat >= BEAT_W'(HDR_PULSES));
    assign s_adv     = r_busy & i_adv_ok;
    // next word enters while the final slot of this one moves on
    assign i_in.ready = ~r_busy | (i_adv_ok & s_last);
    assign s_take    = i_in.valid & i_in.ready;

    always_comb begin
        n_busy  = r_busy;
        n_beat  = r_beat;
        n_shift = r_shift;
        n_prev  = r_prev;
        if (s_adv) begin
            n_beat = r_beat + BEAT_W'(1);
            if (s_is_data) begin
                n_prev  = r_shift[DATA_BITS-1];
                n_shift = r_shift << 1;
            end
            if (s_last) begin
                n_busy = 1'b0;
            end
        end
        if (s_take) begin
            n_busy  = 1'b1;
            n_beat  = '0;
            n_shift = DATA_BITS'(i_in.data_word[LOAD_W-1:0]);
            n_prev  = 1'b1;   // last header pulse counts as a 1
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else begin
            r_busy <= n_busy;
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_prev  <= n_prev;
    end

    assign o_beat_valid     = r_busy;
    assign o_beat.is_data   = s_is_data;
    assign o_beat.hdr_sel   = r_beat[HDR_IDX_W-1:0];
    assign o_beat.cur_bit   = r_shift[DATA_BITS-1];
    assign o_beat.prev_bit  = r_prev;
    assign o_beat.last      = s_last;

endmodule

`default_nettype wire

// ===== sv/ppm_calc.sv =====
// Interval stage: computes tick count for one slot into the output register.
// Depends on ppm_pkg and ppm_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ppm_calc (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire ppm_pkg::t_cfg  i_cfg,
    input  wire logic     i_beat_valid,
    input  wire ppm_pkg::t_beat i_beat,
    output      logic     o_adv_ok,
    ppm_out_if.source     o_out
);
    import ppm_pkg::*;

    logic                r_valid, n_valid;
    logic [TICKS_W-1:0]  r_ticks, n_ticks;
    logic                r_data,  r_last;
    logic [FACTOR_W-1:0] s_factor;

    assign o_adv_ok = ~r_valid | o_out.ready;

    always_comb begin
        if (i_beat.cur_bit == i_beat.prev_bit) begin
            s_factor = i_cfg.base_factor;
        end else if (i_beat.prev_bit) begin
            s_factor = i_cfg.long_factor;
        end else begin
            s_factor = i_cfg.short_factor;
        end

        if (i_beat.is_data) begin
            n_ticks = TICKS_W'({s_factor, 4'b0000});
        end else if (i_beat.hdr_sel == '0) begin
            n_ticks = i_cfg.start_delay;
        end else begin
            // 7 x 5 bits, at most 3810
            n_ticks = TICKS_W'(i_cfg.base_factor) * TICKS_W'(hdr_space(i_beat.hdr_sel));
        end

        n_valid = r_valid;
        if (o_adv_ok) begin
            n_valid = i_beat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv_ok && i_beat_valid) begin
            r_ticks <= n_ticks;
            r_data  <= i_beat.is_data;
            r_last  <= i_beat.last;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.interval_ticks = r_ticks;
    assign o_out.is_data_pulse  = r_data;
    assign o_out.last_pulse     = r_last;

endmodule

`default_nettype wire

// ===== sv/ppm_pulse_interval_encoder_top.sv =====
// PPM pulse interval encoder, top level: one data word in, 16 + DATA_BITS intervals out.
// Words are held in the sequencer registers, their intervals in the output register.
// Throughput: one interval per cycle while the sink is ready and words keep coming,
//   set by the single output register draining one slot per transfer.
// Reset: synchronous, active low; clears sequencer and output valid, restores factor
//   and start delay registers to 50 / 55 / 45 / 300.
`timescale 1ns / 1ps
`default_nettype none

module ppm_pulse_interval_encoder_top #(
    parameter int unsigned DATA_BITS = ppm_pkg::DATA_BITS_DEF   // 2..32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ppm_in_if.sink                              i_in,
    ppm_out_if.source                           o_out,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [ppm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [ppm_pkg::APB_DATA_W-1:0] i_pwdata,
    output      logic [ppm_pkg::APB_DATA_W-1:0] o_prdata,
    output      logic                           o_pready
);
    import ppm_pkg::*;

    // Structure:
    //   ppm_cfg  - APB registers, user writes only between frames (block does not check)
    //   ppm_seq  - captures the word, walks header slots then data bits MSB first;
    //              takes the next word in the cycle its final slot moves on
    //   ppm_calc - factor select / constant multiply into the output register
    t_cfg  s_cfg;
    t_beat s_beat;
    logic  s_beat_valid;
    logic  s_adv_ok;

    ppm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (s_cfg)
    );

    ppm_seq #(
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_adv_ok     (s_adv_ok),
        .o_beat_valid (s_beat_valid),
        .o_beat       (s_beat)
    );

    ppm_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (s_cfg),
        .i_beat_valid (s_beat_valid),
        .i_beat       (s_beat),
        .o_adv_ok     (s_adv_ok),
        .o_out        (o_out)
    );

`ifndef NO_ASSERTIONS
    // a fresh word always starts at the start-delay slot
    a_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=>
            (s_beat_valid && !s_beat.is_data && s_beat.hdr_sel == '0))
        else $error("frame did not start at start-delay slot");

    // a new word is taken mid-frame only while the final slot leaves
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.ready && s_beat_valid) |-> (s_beat.last && s_adv_ok))
        else $error("input taken before frame end");

    // the final pulse of a frame is always a data pulse
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_pulse) |-> o_out.is_data_pulse)
        else $error("last pulse flagged on a header slot");

    // after the final pulse leaves, the next one is a header pulse
    a_header_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_pulse) ##1 o_out.valid |->
            !o_out.is_data_pulse)
        else $error("frame did not restart with header");
`endif

endmodule

`default_nettype wire

// ===== dv/ppm_pulse_interval_encoder_top_tb.sv =====
// Self-checking testbench for ppm_pulse_interval_encoder_top: words in, pulse intervals out.
// Depends on ppm_pkg (widths, register indexes, config struct) and ppm_ifs (channels).
`timescale 1ns / 1ps

module ppm_pulse_interval_encoder_top_tb;

    import ppm_pkg::*;

    localparam int unsigned N_DATA     = DATA_BITS_DEF;
    localparam int unsigned FRAME_LEN  = HDR_PULSES + N_DATA;
    localparam int          CYCLE_CAP  = 200_000;
    localparam int          TAIL_WAIT  = 40;    // > latency + one frame drain
    localparam int          IDLE_PCT   = 25;
    localparam int          REPORT_MAX = 10;

    // header spacings in base_factor units, slots 1..15 of the frame
    localparam int HDR_SPACING [HDR_PULSES-1] = '{
        23, 16, 20, 25, 29, 27, 24, 22, 28, 17, 21, 30, 18, 26, 19
    };

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic               is_data;
        logic               last;
    } t_pulse;

    logic i_clk;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    ppm_in_if  word_ch ();
    ppm_out_if pulse_ch ();

    ppm_pulse_interval_encoder_top #(
        .DATA_BITS (N_DATA)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (word_ch),
        .o_out     (pulse_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Shadow of the factor / delay registers, kept in step with every write.
    t_cfg   cfg;
    // Intervals still owed by the block, oldest first.
    t_pulse pending_pulses [$];
    int     mismatches;
    int     cycles;
    // When set, neither side idles: back-to-back transfers on both channels.
    logic   steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one frame of FRAME_LEN intervals per accepted word.
    // Header: start delay, then fifteen fixed spacings times base_factor.
    // Data: MSB first, 16 x factor picked from the bit and the one before it,
    // with the last header pulse standing in as a preceding 1.
    // ------------------------------------------------------------------
    function automatic void encode_frame(input logic [WORD_W-1:0] word);
        t_pulse              p;
        logic                prev_b;
        logic                cur;
        logic [FACTOR_W-1:0] f;
        int                  k;

        k = 0;
        p = '{ticks: cfg.start_delay, is_data: 1'b0, last: (k == FRAME_LEN - 1)};
        pending_pulses.push_back(p);
        k++;
        for (int i = 0; i < HDR_PULSES - 1; i++) begin
            p.ticks   = TICKS_W'(HDR_SPACING[i] * int'(cfg.base_factor));
            p.is_data = 1'b0;
            p.last    = (k == FRAME_LEN - 1);
            pending_pulses.push_back(p);
            k++;
        end
        prev_b = 1'b1;
        for (int i = N_DATA - 1; i >= 0; i--) begin
            // bits above the input word width go out as zeros
            cur = (i < WORD_W) ? word[i] : 1'b0;
            if (cur == prev_b) begin
                f = cfg.base_factor;
            end else if (prev_b) begin
                f = cfg.long_factor;      // one to zero
            end else begin
                f = cfg.short_factor;     // zero to one
            end
            p.ticks   = TICKS_W'(16 * int'(f));
            p.is_data = 1'b1;
            p.last    = (k == FRAME_LEN - 1);
            pending_pulses.push_back(p);
            k++;
            prev_b = cur;
        end
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_BASE:  return APB_DATA_W'(cfg.base_factor);
            REG_LONG:  return APB_DATA_W'(cfg.long_factor);
            REG_SHORT: return APB_DATA_W'(cfg.short_factor);
            default:   return APB_DATA_W'(cfg.start_delay);
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every output transfer is compared with the oldest
    // pending interval. Sampled at the rising edge; all TB drives happen on
    // the falling edge, so the sampled values are the settled pre-edge ones.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pulse want;
        if (i_rst_n && pulse_ch.valid && pulse_ch.ready) begin
            if (pending_pulses.size() == 0) begin
                flag_mismatch($sformatf("unexpected interval ticks=%0d data=%0b last=%0b",
                              pulse_ch.interval_ticks, pulse_ch.is_data_pulse,
                              pulse_ch.last_pulse));
            end else begin
                want = pending_pulses.pop_front();
                if (pulse_ch.interval_ticks !== want.ticks ||
                    pulse_ch.is_data_pulse  !== want.is_data ||
                    pulse_ch.last_pulse     !== want.last) begin
                    flag_mismatch($sformatf(
                        "interval exp ticks=%0d data=%0b last=%0b, got ticks=%0d data=%0b last=%0b",
                        want.ticks, want.is_data, want.last, pulse_ch.interval_ticks,
                        pulse_ch.is_data_pulse, pulse_ch.last_pulse));
                end
            end
        end
    end

    // Sink side back-pressure: stalls about a quarter of the cycles unless steady.
    initial begin
        pulse_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pulse_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // One word transfer. Valid is left high on return so a following word can
    // go out back to back; the next falling edge either keeps or drops it.
    task automatic send_word(input logic [WORD_W-1:0] word);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            word_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= word;
        do @(posedge i_clk); while (!(word_ch.valid && word_ch.ready));
        encode_frame(word);
    endtask

    // Drop valid and wait for every owed interval, leaving the block idle.
    task automatic drain;
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge i_clk);
    endtask

    // Setup + access phase; the transfer completes at the edge with pready high.
    task automatic apb_xfer(input t_reg_idx idx, input logic wr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [APB_DATA_W-1:0] got;
        apb_xfer(idx, 1'b0, '0, got);
        if (got !== reg_value(idx)) begin
            flag_mismatch($sformatf("reg %s read exp 0x%0h got 0x%0h",
                          idx.name(), reg_value(idx), got));
        end
    endtask

    // Upper pwdata bits beyond the field are don't-care and must be dropped.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_xfer(idx, 1'b1, value, unused);
        case (idx)
            REG_BASE:  cfg.base_factor  = value[FACTOR_W-1:0];
            REG_LONG:  cfg.long_factor  = value[FACTOR_W-1:0];
            REG_SHORT: cfg.short_factor = value[FACTOR_W-1:0];
            default:   cfg.start_delay  = value[TICKS_W-1:0];
        endcase
        check_reg(idx);
    endtask

    task automatic set_factors(input logic [APB_DATA_W-1:0] base_v,
                               input logic [APB_DATA_W-1:0] long_v,
                               input logic [APB_DATA_W-1:0] short_v,
                               input logic [APB_DATA_W-1:0] start_v);
        drain();
        write_reg(REG_BASE,  base_v);
        write_reg(REG_LONG,  long_v);
        write_reg(REG_SHORT, short_v);
        write_reg(REG_START, start_v);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back, then all-zero / all-one / alternating words and
    // single-bit words under the reset factors.
    task automatic test_reset_defaults;
        check_reg(REG_BASE);
        check_reg(REG_LONG);
        check_reg(REG_SHORT);
        check_reg(REG_START);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'hAAAA);
        send_word(16'h5555);
        send_word(16'h8000);
        send_word(16'h0001);
    endtask

    // Field extremes: largest factors and delay (largest product 30 x 127),
    // smallest legal values, and factors written as zero (0-tick intervals).
    task automatic test_factor_extremes;
        set_factors(32'd127, 32'd127, 32'd127, 32'd4095);
        send_word(16'h0F0F);
        send_word(16'hFFFF);
        send_word(16'h5555);
        set_factors(32'd1, 32'd1, 32'd1, 32'd0);
        send_word(16'hA5A5);
        send_word(16'h0000);
        set_factors(32'd0, 32'd0, 32'd0, 32'd0);
        send_word(16'h6996);
        send_word(16'hAAAA);
        // distinct factors so a swapped long/short choice shows up
        set_factors(32'd127, 32'd1, 32'd64, 32'd1);
        send_word(16'h3C3C);
        send_word(16'hC3C3);
    endtask

    // Random register values (junk in the upper pwdata bits) and shaped words:
    // long runs, near-alternating, sparse and fully random.
    task automatic test_random_words;
        logic [WORD_W-1:0] w;
        logic              b;

        for (int phase = 0; phase < 4; phase++) begin
            set_factors($urandom, $urandom, $urandom, $urandom);
            steady = (phase == 2);
            for (int n = 0; n < 24; n++) begin
                case ($urandom_range(3))
                    0: w = WORD_W'($urandom);
                    1: begin
                        b = 1'($urandom_range(1));
                        for (int i = 0; i < WORD_W; i++) begin
                            if ($urandom_range(5) == 0) b = ~b;
                            w[i] = b;
                        end
                    end
                    2: w = 16'hAAAA ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
                    default: w = (WORD_W'(1) << $urandom_range(WORD_W - 1)) ^
                                 (($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
                endcase
                send_word(w);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        mismatches        = 0;
        cycles            = 0;
        steady            = 1'b0;
        cfg = '{base_factor: BASE_RST, long_factor: LONG_RST,
                short_factor: SHORT_RST, start_delay: START_RST};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_factor_extremes();
        test_random_words();

        // everything accepted: wait for the last frame, then a quiet tail in
        // which any extra interval would be flagged by the checker
        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ppm_pkg.sv
sv/ppm_ifs.sv
sv/ppm_cfg.sv
sv/ppm_seq.sv
sv/ppm_calc.sv
sv/ppm_pulse_interval_encoder_top.sv
dv/ppm_pulse_interval_encoder_top_tb.sv
